>>> rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, constants and types of the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // delay store geometry, depth is a power of two
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int DIST_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int FRAC_SH  = GAIN_W - 1;
  localparam int QUOT_W   = PROD_W - FRAC_SH;
  localparam int SUM_W    = QUOT_W + 1;

  // rounding bias for the Q1.15 gain product, half of one output lsb
  localparam int ROUND_BIAS = 1 << (FRAC_SH - 1);

  // saturation limits of a Q1.23 sample
  localparam logic signed [SUM_W-1:0] SAMPLE_MAX = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -SUM_W'(1 << (SAMPLE_W - 1));

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SAMPLES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TAP_BACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TAP_BACK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN  = 2'd3;

  localparam logic [DIST_W-1:0]        RST_DELAY_SAMPLES  = 16'd22050;
  localparam logic [DIST_W-1:0]        RST_LEFT_TAP_BACK  = 16'd0;
  localparam logic [DIST_W-1:0]        RST_RIGHT_TAP_BACK = 16'd11025;
  localparam logic signed [GAIN_W-1:0] RST_FEEDBACK_GAIN  = 16'sd16384;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = OUTQ_AW + 1;

  // which tap a store read belongs to
  typedef enum logic [1:0] {
    TAP_FEEDBACK = 2'd0,
    TAP_LEFT     = 2'd1,
    TAP_RIGHT    = 2'd2
  } tap_kind_t;

  // control that travels with each store read
  typedef struct packed {
    logic                       valid;
    tap_kind_t                  kind;
    logic                       zero;
    logic signed [SAMPLE_W-1:0] x;
  } tap_tag_t;

endpackage

>>> rtl/core/sfd_seq.sv
// ----------------------------------------------------------------------------
// sfd_seq
// Read sequencer: takes input items, issues the feedback, left and right tap
// reads in turn and keeps the write pointer and the fill state.
// ----------------------------------------------------------------------------
module sfd_seq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               credit_ok,
  input  logic [sfd_pkg::DIST_W-1:0]         delay_samples,
  input  logic [sfd_pkg::DIST_W-1:0]         left_tap_back,
  input  logic [sfd_pkg::DIST_W-1:0]         right_tap_back,
  output logic                               accept,
  output logic [sfd_pkg::ADDR_W-1:0]         rd_addr,
  output sfd_pkg::tap_tag_t                  rd_tag,
  output logic [sfd_pkg::ADDR_W-1:0]         wr_addr
);

  typedef enum logic [3:0] {
    S_IDLE      = 4'b0001,
    S_TAP_FB    = 4'b0010,
    S_TAP_LEFT  = 4'b0100,
    S_TAP_RIGHT = 4'b1000
  } seq_state_t;

  localparam logic [sfd_pkg::ADDR_W-1:0] LAST_SLOT = sfd_pkg::ADDR_W'(sfd_pkg::STORE_DEPTH - 1);

  seq_state_t                        state, state_next;
  logic signed [sfd_pkg::SAMPLE_W-1:0] x;
  logic [sfd_pkg::ADDR_W-1:0]        wp;
  logic                              full;
  logic [sfd_pkg::DIST_W-1:0]        tap_dist;
  logic [sfd_pkg::ADDR_W-1:0]        slot;
  logic                              slot_open;

  // a new item enters once the last read of the previous one goes out
  assign slot_open = (state == S_IDLE) || (state == S_TAP_RIGHT);
  assign in_stall  = !(slot_open && credit_ok);
  assign accept    = in_valid && !in_stall;

  // state transitions
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      state_next = accept ? S_TAP_FB : S_IDLE;
      S_TAP_FB:    state_next = S_TAP_LEFT;
      S_TAP_LEFT:  state_next = S_TAP_RIGHT;
      S_TAP_RIGHT: state_next = accept ? S_TAP_FB : S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input sample holding
  always_ff @(posedge clk) begin
    if (accept) begin
      x <= in_sample;
    end
  end

  // tap distance for the current read
  always_comb begin
    tap_dist = delay_samples;
    unique case (state)
      S_TAP_FB:    tap_dist = delay_samples;
      S_TAP_LEFT:  tap_dist = left_tap_back;
      S_TAP_RIGHT: tap_dist = right_tap_back;
      default:     tap_dist = delay_samples;
    endcase
  end

  // slot behind the write pointer, an unwritten slot reads as zero
  assign slot    = wp - sfd_pkg::ADDR_W'(tap_dist);
  assign rd_addr = slot;

  always_comb begin
    rd_tag.valid = (state != S_IDLE);
    rd_tag.kind  = sfd_pkg::TAP_FEEDBACK;
    if (state == S_TAP_LEFT) begin
      rd_tag.kind = sfd_pkg::TAP_LEFT;
    end else if (state == S_TAP_RIGHT) begin
      rd_tag.kind = sfd_pkg::TAP_RIGHT;
    end
    rd_tag.zero = !(full || (slot < wp));
    rd_tag.x    = x;
  end

  // the feedback write lands in the right-tap cycle, then the pointer moves
  assign wr_addr = wp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      full <= 1'b0;
    end else if (state == S_TAP_RIGHT) begin
      if (wp == LAST_SLOT) begin
        wp   <= '0;
        full <= 1'b1;
      end else begin
        wp <= wp + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/sfd_store.sv
// ----------------------------------------------------------------------------
// sfd_store
// Delay store: one write port and one read port with registered read data,
// the read tag follows the data.
// ----------------------------------------------------------------------------
module sfd_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [sfd_pkg::ADDR_W-1:0]         wr_addr,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [sfd_pkg::ADDR_W-1:0]         rd_addr,
  input  sfd_pkg::tap_tag_t                  rd_tag,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] rd_data,
  output sfd_pkg::tap_tag_t                  rd_tag_q
);

  logic signed [sfd_pkg::SAMPLE_W-1:0] mem [sfd_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_tag.valid) begin
      rd_data <= mem[rd_addr];
    end
  end

  // tag alongside the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag_q <= '0;
    end else begin
      rd_tag_q <= rd_tag;
    end
  end

endmodule

>>> rtl/core/sfd_mix.sv
// ----------------------------------------------------------------------------
// sfd_mix
// Gain and mix pipeline: one shared multiplier stage, then round, add the
// input sample and saturate; routes the result to the store or the queue.
// ----------------------------------------------------------------------------
module sfd_mix (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [sfd_pkg::GAIN_W-1:0]   feedback_gain,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] rd_data,
  input  sfd_pkg::tap_tag_t                  rd_tag_q,
  output logic                               wr_en,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] wr_data,
  output logic                               push,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] push_left,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] push_right
);

  logic signed [sfd_pkg::SAMPLE_W-1:0] tap;
  logic signed [sfd_pkg::PROD_W-1:0]   prod;
  sfd_pkg::tap_tag_t                   prod_tag;
  logic signed [sfd_pkg::PROD_W-1:0]   biased;
  logic signed [sfd_pkg::QUOT_W-1:0]   quot;
  logic signed [sfd_pkg::SUM_W-1:0]    sum;
  logic signed [sfd_pkg::SAMPLE_W-1:0] sat;
  logic signed [sfd_pkg::SAMPLE_W-1:0] left_hold;

  // multiplier stage, unwritten slots count as silence
  assign tap = rd_tag_q.zero ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (rd_tag_q.valid) begin
      prod <= sfd_pkg::PROD_W'(feedback_gain) * sfd_pkg::PROD_W'(tap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_tag <= '0;
    end else begin
      prod_tag <= rd_tag_q;
    end
  end

  // round half up to Q1.23, add input, clamp
  assign biased = prod + sfd_pkg::PROD_W'(sfd_pkg::ROUND_BIAS);
  assign quot   = biased[sfd_pkg::PROD_W-1:sfd_pkg::FRAC_SH];
  assign sum    = sfd_pkg::SUM_W'(prod_tag.x) + sfd_pkg::SUM_W'(quot);

  always_comb begin
    if (sum > sfd_pkg::SAMPLE_MAX) begin
      sat = sfd_pkg::SAMPLE_MAX[sfd_pkg::SAMPLE_W-1:0];
    end else if (sum < sfd_pkg::SAMPLE_MIN) begin
      sat = sfd_pkg::SAMPLE_MIN[sfd_pkg::SAMPLE_W-1:0];
    end else begin
      sat = sum[sfd_pkg::SAMPLE_W-1:0];
    end
  end

  // route by tap kind
  always_comb begin
    wr_en = 1'b0;
    push  = 1'b0;
    case (prod_tag.kind)
      sfd_pkg::TAP_FEEDBACK: wr_en = prod_tag.valid;
      sfd_pkg::TAP_RIGHT:    push  = prod_tag.valid;
      default: ;
    endcase
  end

  assign wr_data    = sat;
  assign push_left  = left_hold;
  assign push_right = sat;

  // left result waits for its right partner
  always_ff @(posedge clk) begin
    if (prod_tag.valid && (prod_tag.kind == sfd_pkg::TAP_LEFT)) begin
      left_hold <= sat;
    end
  end

endmodule

>>> rtl/core/sfd_outq.sv
// ----------------------------------------------------------------------------
// sfd_outq
// Result queue with admission credit: an item is taken only when its
// result is sure to find room here.
// ----------------------------------------------------------------------------
module sfd_outq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               push,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] push_left,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] push_right,
  output logic                               credit_ok,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] left_sample,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] right_sample
);

  logic signed [sfd_pkg::SAMPLE_W-1:0] q_left  [sfd_pkg::OUTQ_DEPTH];
  logic signed [sfd_pkg::SAMPLE_W-1:0] q_right [sfd_pkg::OUTQ_DEPTH];
  logic [sfd_pkg::OUTQ_AW-1:0]         wr_ptr;
  logic [sfd_pkg::OUTQ_AW-1:0]         rd_ptr;
  logic [sfd_pkg::OUTQ_CW-1:0]         count;
  logic [sfd_pkg::OUTQ_CW-1:0]         inflight;
  logic [sfd_pkg::OUTQ_CW:0]           reserved;
  logic                                pop;

  // credit covers stored results and items still in the pipeline
  assign reserved  = {1'b0, count} + {1'b0, inflight};
  assign credit_ok = reserved < (sfd_pkg::OUTQ_CW + 1)'(sfd_pkg::OUTQ_DEPTH);

  assign out_valid    = (count != '0);
  assign pop          = out_valid && !out_stall;
  assign left_sample  = q_left[rd_ptr];
  assign right_sample = q_right[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_left[wr_ptr]  <= push_left;
      q_right[wr_ptr] <= push_right;
    end
  end

  // pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      inflight <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
      if (accept && !push) begin
        inflight <= inflight + 1'b1;
      end else if (push && !accept) begin
        inflight <= inflight - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/stereo_feedback_delay.sv
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Mono in, stereo out feedback delay line over a ring store of samples.
// ----------------------------------------------------------------------------
// Each item takes one Q1.23 sample and yields left = in + gain*left tap and
// right = in + gain*right tap, while in + gain*(sample delay_samples back) is
// written at the write pointer. The store has one read port and each item
// needs three tap reads (feedback, left, right); a new item can enter with
// the previous item's right-tap read. Results pass the store read and product
// registers into the output queue; it holds 4 results and input stalls when
// queued plus pending results would exceed that. After reset the store counts
// as all zeros with no clearing pass: a fill flag and the write pointer mark
// which slots were written. Configuration writes belong in idle periods.
// ----------------------------------------------------------------------------
module stereo_feedback_delay (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sfd_pkg::SAMPLE_W-1:0]   left_sample,
  output logic signed [sfd_pkg::SAMPLE_W-1:0]   right_sample
);

  logic [sfd_pkg::DIST_W-1:0]          delay_samples;
  logic [sfd_pkg::DIST_W-1:0]          left_tap_back;
  logic [sfd_pkg::DIST_W-1:0]          right_tap_back;
  logic signed [sfd_pkg::GAIN_W-1:0]   feedback_gain;

  logic                                credit_ok;
  logic                                accept;
  logic [sfd_pkg::ADDR_W-1:0]          rd_addr;
  sfd_pkg::tap_tag_t                   rd_tag;
  sfd_pkg::tap_tag_t                   rd_tag_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] rd_data;
  logic [sfd_pkg::ADDR_W-1:0]          wr_addr;
  logic                                wr_en;
  logic signed [sfd_pkg::SAMPLE_W-1:0] wr_data;
  logic                                push;
  logic signed [sfd_pkg::SAMPLE_W-1:0] push_left;
  logic signed [sfd_pkg::SAMPLE_W-1:0] push_right;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples  <= sfd_pkg::RST_DELAY_SAMPLES;
      left_tap_back  <= sfd_pkg::RST_LEFT_TAP_BACK;
      right_tap_back <= sfd_pkg::RST_RIGHT_TAP_BACK;
      feedback_gain  <= sfd_pkg::RST_FEEDBACK_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::CFG_DELAY_SAMPLES:  delay_samples  <= cfg_data;
        sfd_pkg::CFG_LEFT_TAP_BACK:  left_tap_back  <= cfg_data;
        sfd_pkg::CFG_RIGHT_TAP_BACK: right_tap_back <= cfg_data;
        sfd_pkg::CFG_FEEDBACK_GAIN:  feedback_gain  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // read sequencer and write pointer
  sfd_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .credit_ok      (credit_ok),
    .delay_samples  (delay_samples),
    .left_tap_back  (left_tap_back),
    .right_tap_back (right_tap_back),
    .accept         (accept),
    .rd_addr        (rd_addr),
    .rd_tag         (rd_tag),
    .wr_addr        (wr_addr)
  );

  // delay store
  sfd_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_tag   (rd_tag),
    .rd_data  (rd_data),
    .rd_tag_q (rd_tag_q)
  );

  // gain, mix and saturate
  sfd_mix u_mix (
    .clk           (clk),
    .rst           (rst),
    .feedback_gain (feedback_gain),
    .rd_data       (rd_data),
    .rd_tag_q      (rd_tag_q),
    .wr_en         (wr_en),
    .wr_data       (wr_data),
    .push          (push),
    .push_left     (push_left),
    .push_right    (push_right)
  );

  // result queue
  sfd_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .push         (push),
    .push_left    (push_left),
    .push_right   (push_right),
    .credit_ok    (credit_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample)
  );

endmodule
